[rtl/case_insensitive_substring_search_assert.svh]
// Assertion macros used by the substring search RTL
`ifndef CASE_INSENSITIVE_SUBSTRING_SEARCH_ASSERT_SVH
`define CASE_INSENSITIVE_SUBSTRING_SEARCH_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CIS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define CIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/cis_pkg.sv]
// Types, codes and helpers for the substring search block
`timescale 1ns / 1ps
`default_nettype none

package cis_pkg;

    localparam int CHAR_W = 8;
    localparam int POS_W  = 10;

    localparam logic [1:0] REQ_CLEAR   = 2'd0;
    localparam logic [1:0] REQ_PATTERN = 2'd1;
    localparam logic [1:0] REQ_TEXT    = 2'd2;
    localparam logic [1:0] REQ_EOT     = 2'd3;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'd32;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CHAR_W-1:0] char_value;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] match_position;
    } t_rsp;

    typedef struct packed {
        logic pat_wr;
        logic txt_wr;
        logic hist_clr;
    } t_match_ctl;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/cis_stream_if.sv]
// Valid/ready stream channel carrying one item per handshake
`timescale 1ns / 1ps
`default_nettype none

interface cis_stream_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/cis_matcher.sv]
// Pattern store and prefix-match vector, one text byte per cycle while txt_wr is set
`timescale 1ns / 1ps
`default_nettype none

module cis_matcher
    import cis_pkg::*;
#(
    parameter int PATTERN_MAX = 128,
    parameter int PL_W        = 8,
    parameter int PI_W        = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_match_ctl        i_ctl,
    input  wire logic [CHAR_W-1:0] i_char,
    input  wire logic [PL_W-1:0]   i_pat_len,
    output logic                   o_hit
);

    logic [CHAR_W-1:0]      r_pat [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] r_m;
    logic [PATTERN_MAX-1:0] n_m;
    logic [PI_W-1:0]        w_wr_idx;
    logic [PI_W-1:0]        w_sel;

    assign w_wr_idx = i_pat_len[PI_W-1:0];
    assign w_sel    = PI_W'(i_pat_len - PL_W'(1));

    // r_m[k]: last k+1 text bytes equal pattern bytes 0..k
    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        if (k == 0) begin : g_first
            assign n_m[k] = (i_char == r_pat[k]);
        end else begin : g_rest
            assign n_m[k] = r_m[k-1] && (i_char == r_pat[k]);
        end
    end

    assign o_hit = n_m[w_sel] && (i_pat_len != '0);

    always_ff @(posedge i_clk) begin
        if (i_ctl.pat_wr) begin
            r_pat[w_wr_idx] <= i_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.hist_clr) begin
            r_m <= '0;
        end else if (i_ctl.txt_wr) begin
            r_m <= n_m;
        end
    end

endmodule

`default_nettype wire

[rtl/case_insensitive_substring_search.sv]
// An end-of-text item passes r_s1; its result is registered in r_out.
// Throughput: 1 item per cycle; the single-entry result register stalls the
//   input stage only while an end-of-text item waits behind an untaken result.
// Every text byte is compared against all pattern positions in parallel.
// Reset (synchronous, active low) clears counts, flags and both stages;
//   the pattern store is left uninitialized.
`timescale 1ns / 1ps
`default_nettype none
`include "case_insensitive_substring_search_assert.svh"

module case_insensitive_substring_search
    import cis_pkg::*;
#(
    parameter int PATTERN_MAX = 128,
    parameter int TEXT_MAX    = 512
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    cis_stream_if.sink   i_req,
    cis_stream_if.source o_rsp
);

    localparam int PL_W = $clog2(PATTERN_MAX + 1);
    localparam int PI_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int TC_W = $clog2(TEXT_MAX + 1);
    localparam int SW   = ((TC_W > PL_W) ? TC_W : PL_W) + 1;

    logic             r_s1_valid;
    t_req             r_s1;
    logic             r_out_valid;
    t_rsp             r_out;
    logic [PL_W-1:0]  r_pat_len;
    logic [TC_W-1:0]  r_txt_cnt;
    logic             r_found;
    logic [TC_W-1:0]  r_found_start;
    logic             r_ovf;

    logic [PL_W-1:0]  n_pat_len;
    logic [TC_W-1:0]  n_txt_cnt;
    logic             n_found;
    logic [TC_W-1:0]  n_found_start;
    logic             n_ovf;
    t_rsp             n_out;

    logic             w_out_free;
    logic             w_s1_adv;
    logic             w_accept;
    logic             w_eot_go;
    logic             w_hit;
    t_match_ctl       w_ctl;
    logic [SW-1:0]    w_start_full;
    logic [TC_W+POS_W-1:0] w_start_ext;

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_s1_adv   = r_s1_valid && ((r_s1.req_type != REQ_EOT) || w_out_free);
    assign i_req.ready = !r_s1_valid || w_s1_adv;
    assign w_accept   = i_req.valid && i_req.ready;
    assign w_eot_go   = w_s1_adv && (r_s1.req_type == REQ_EOT);

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    assign w_start_full = SW'(r_txt_cnt) + SW'(2) - SW'(r_pat_len);
    assign w_start_ext  = {{POS_W{1'b0}}, r_found_start};

    always_comb begin
        w_ctl         = '0;
        n_pat_len     = r_pat_len;
        n_txt_cnt     = r_txt_cnt;
        n_found       = r_found;
        n_found_start = r_found_start;
        n_ovf         = r_ovf;
        n_out         = r_out;
        if (w_s1_adv) begin
            unique case (r_s1.req_type)
                REQ_CLEAR: begin
                    w_ctl.hist_clr = 1'b1;
                    n_pat_len      = '0;
                    n_txt_cnt      = '0;
                    n_found        = 1'b0;
                    n_found_start  = '0;
                    n_ovf          = 1'b0;
                end
                REQ_PATTERN: begin
                    if (r_txt_cnt == '0) begin
                        if (r_pat_len < PL_W'(PATTERN_MAX)) begin
                            w_ctl.pat_wr = 1'b1;
                            n_pat_len    = r_pat_len + PL_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
                REQ_TEXT: begin
                    if (r_txt_cnt >= TC_W'(TEXT_MAX)) begin
                        n_ovf = 1'b1;
                    end else begin
                        w_ctl.txt_wr = 1'b1;
                        n_txt_cnt    = r_txt_cnt + TC_W'(1);
                        if (!r_found && w_hit) begin
                            n_found       = 1'b1;
                            n_found_start = w_start_full[TC_W-1:0];
                        end
                    end
                end
                REQ_EOT: begin
                    w_ctl.hist_clr = 1'b1;
                    n_txt_cnt      = '0;
                    n_found        = 1'b0;
                    n_found_start  = '0;
                    n_ovf          = 1'b0;
                    n_out.match_position = '0;
                    if (r_ovf) begin
                        n_out.status = ST_OVERFLOW;
                        if (r_found) begin
                            n_out.match_position = w_start_ext[POS_W-1:0];
                        end
                    end else if (r_txt_cnt == '0) begin
                        n_out.status = ST_EMPTY;
                    end else if (r_pat_len == '0) begin
                        n_out.status = ST_NOT_FOUND;
                    end else if (r_found) begin
                        n_out.status         = ST_FOUND;
                        n_out.match_position = w_start_ext[POS_W-1:0];
                    end else begin
                        n_out.status = ST_NOT_FOUND;
                    end
                end
                default: begin
                    w_ctl = '0;
                end
            endcase
        end
    end

    cis_matcher #(
        .PATTERN_MAX (PATTERN_MAX),
        .PL_W        (PL_W),
        .PI_W        (PI_W)
    ) u_matcher (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_char    (r_s1.char_value),
        .i_pat_len (r_pat_len),
        .o_hit     (w_hit)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1.req_type   <= i_req.data.req_type;
            r_s1.char_value <= fold_case(i_req.data.char_value);
        end
        if (w_eot_go) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_pat_len     <= '0;
            r_txt_cnt     <= '0;
            r_found       <= 1'b0;
            r_found_start <= '0;
            r_ovf         <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_eot_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            r_pat_len     <= n_pat_len;
            r_txt_cnt     <= n_txt_cnt;
            r_found       <= n_found;
            r_found_start <= n_found_start;
            r_ovf         <= n_ovf;
        end
    end

    `CIS_ASSERT_IMPL(a_found_needs_pattern, i_clk, i_rst_n, r_found, r_pat_len != '0)
    `CIS_ASSERT_IMPL(a_txt_cnt_bound, i_clk, i_rst_n, 1'b1, r_txt_cnt <= TC_W'(TEXT_MAX))
    `CIS_ASSERT_IMPL(a_pat_len_bound, i_clk, i_rst_n, 1'b1, r_pat_len <= PL_W'(PATTERN_MAX))
    `CIS_ASSERT_IMPL(a_start_in_text, i_clk, i_rst_n, r_found, (r_found_start != '0) && (r_found_start <= r_txt_cnt))
    `CIS_ASSERT_NEXT(a_eot_held, i_clk, i_rst_n, r_s1_valid && (r_s1.req_type == REQ_EOT) && !w_out_free, r_s1_valid && (r_s1.req_type == REQ_EOT))

endmodule

`default_nettype wire

[tb/tb_case_insensitive_substring_search.sv]
// Self-checking testbench for case_insensitive_substring_search: streams requests, predicts reports
`timescale 1ns / 1ps

module tb_case_insensitive_substring_search;
    import cis_pkg::*;

    localparam int PAT_CAP     = 128;
    localparam int TEXT_CAP    = 512;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_AT     = 15;
    localparam int HOLD_CYCLES = 250;
    localparam int SHOW_MAX    = 10;

    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cis_stream_if #(.t_data(t_req)) req_if ();
    cis_stream_if #(.t_data(t_rsp)) rsp_if ();

    case_insensitive_substring_search #(
        .PATTERN_MAX(PAT_CAP),
        .TEXT_MAX   (TEXT_CAP)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    t_req request_backlog [$];
    t_rsp due_reports [$];
    int   total_items = 0;
    int   items_taken = 0;
    int   eot_queued = 0;
    int   reports_seen = 0;
    int   fault_count = 0;
    int   send_gap = 0;
    int   take_gap = 0;
    bit   send_calm = 1'b0;
    bit   take_calm = 1'b0;

    // search state as the block should hold it
    logic [7:0] pat_mem [PAT_CAP];
    logic [7:0] pat_len;
    logic [7:0] win_mem [PAT_CAP];
    logic [9:0] txt_cnt;
    logic       hit_seen;
    logic [9:0] hit_start;
    logic       dropped;

    initial forever #5 i_clk = ~i_clk;

    initial begin
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? (c | CASE_OFFSET) : c;
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z && $urandom_range(0, 1)) begin
            return c - CASE_OFFSET;
        end
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z && $urandom_range(0, 1)) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    // small alphabet so that random text hits the pattern now and then
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return CH_LOWER_A + 8'($urandom_range(0, 3));
            3, 4, 5: return CHAR_UPPER_A + 8'($urandom_range(0, 3));
            6: begin
                case ($urandom_range(0, 9))
                    0: return 8'h00;
                    1: return 8'h40;
                    2: return 8'h5B;
                    3: return 8'h60;
                    4: return 8'h7B;
                    5: return 8'hFF;
                    6: return CHAR_UPPER_A;
                    7: return CHAR_UPPER_Z;
                    8: return CH_LOWER_A;
                    default: return CH_LOWER_Z;
                endcase
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 19);
        if (calm || r < 13) begin
            return 0;
        end
        if (r < 19) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic queue_request(input logic [1:0] kind, input logic [7:0] ch);
        t_req r;
        r.req_type   = kind;
        r.char_value = ch;
        request_backlog.push_back(r);
        total_items++;
        if (kind == REQ_EOT) begin
            eot_queued++;
        end
    endtask

    task automatic forget_text();
        for (int i = 0; i < PAT_CAP; i++) begin
            win_mem[i] = 8'h00;
        end
        txt_cnt   = '0;
        hit_seen  = 1'b0;
        hit_start = '0;
        dropped   = 1'b0;
    endtask

    task automatic advance_search(input t_req r);
        logic [7:0] c;
        t_rsp       rep;
        bit         same;
        c = lower_byte(r.char_value);
        case (r.req_type)
            REQ_CLEAR: begin
                pat_len = '0;
                forget_text();
            end
            REQ_PATTERN: begin
                if (txt_cnt == 0) begin
                    if (pat_len < PAT_CAP) begin
                        pat_mem[pat_len] = c;
                        pat_len++;
                    end else begin
                        dropped = 1'b1;
                    end
                end
            end
            REQ_TEXT: begin
                if (txt_cnt >= TEXT_CAP) begin
                    dropped = 1'b1;
                end else begin
                    for (int i = 0; i < PAT_CAP - 1; i++) begin
                        win_mem[i] = win_mem[i + 1];
                    end
                    win_mem[PAT_CAP - 1] = c;
                    txt_cnt++;
                    if (!hit_seen && pat_len > 0 && txt_cnt >= pat_len) begin
                        same = 1'b1;
                        for (int i = 0; i < pat_len; i++) begin
                            if (win_mem[PAT_CAP - pat_len + i] != pat_mem[i]) begin
                                same = 1'b0;
                            end
                        end
                        if (same) begin
                            hit_seen  = 1'b1;
                            hit_start = txt_cnt - 10'(pat_len) + 10'd1;
                        end
                    end
                end
            end
            default: begin
                rep.match_position = '0;
                if (dropped) begin
                    rep.status = ST_OVERFLOW;
                    if (hit_seen) begin
                        rep.match_position = hit_start;
                    end
                end else if (txt_cnt == 0) begin
                    rep.status = ST_EMPTY;
                end else if (pat_len == 0) begin
                    rep.status = ST_NOT_FOUND;
                end else if (hit_seen) begin
                    rep.status         = ST_FOUND;
                    rep.match_position = hit_start;
                end else begin
                    rep.status = ST_NOT_FOUND;
                end
                due_reports.push_back(rep);
                forget_text();
            end
        endcase
    endtask

    task automatic log_fault(input string what, input t_rsp want, input t_rsp got);
        fault_count++;
        if (fault_count <= SHOW_MAX) begin
            $display("%s: expected status %0d pos %0d, got status %0d pos %0d", what,
                     want.status, want.match_position, got.status, got.match_position);
        end
    endtask

    task automatic check_report(input t_rsp got);
        t_rsp want;
        if (due_reports.size() == 0) begin
            log_fault("report with none pending", '0, got);
        end else begin
            want = due_reports.pop_front();
            if (got.status !== want.status || got.match_position !== want.match_position) begin
                log_fault("report mismatch", want, got);
            end
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        bit offering;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            offering = req_if.valid;
            if (req_if.valid && req_if.ready) begin
                advance_search(req_if.data);
                items_taken++;
                offering = 1'b0;
                if ($urandom_range(0, 79) == 0) begin
                    send_calm = !send_calm;
                end
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end else if (request_backlog.size() > 0) begin
                    req_if.data  <= request_backlog.pop_front();
                    req_if.valid <= 1'b1;
                    send_gap = pick_gap(send_calm);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // report monitor; one long hold lets the block back up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                check_report(rsp_if.data);
                reports_seen++;
                if (reports_seen == HOLD_AT) begin
                    take_gap = HOLD_CYCLES;
                end else begin
                    take_gap = pick_gap(take_calm);
                end
                if ($urandom_range(0, 79) == 0) begin
                    take_calm = !take_calm;
                end
            end else if (take_gap == 0 && !take_calm && $urandom_range(0, 7) == 0) begin
                take_gap = pick_gap(1'b0);
            end
            if (take_gap > 0) begin
                take_gap--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int         idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("tb_case_insensitive_substring_search failed");
        $finish;
    end

    initial begin
        int         seq_idx;
        int         plen;
        int         tlen;
        int         off;
        int         start_items;
        int         small_items;
        bit         big;
        logic [7:0] ch;
        logic [7:0] gen_pat [$];
        logic [7:0] txt_buf [$];

        pat_len = '0;
        forget_text();

        // directed: empty text, empty pattern, folding, zero byte, late pattern byte
        queue_request(REQ_EOT, 8'h00);
        queue_request(REQ_TEXT, 8'h78);
        queue_request(REQ_EOT, 8'hFF);
        queue_request(REQ_PATTERN, CHAR_UPPER_A);
        queue_request(REQ_PATTERN, CH_LOWER_Z);
        queue_request(REQ_PATTERN, 8'h00);
        queue_request(REQ_TEXT, 8'h71);
        queue_request(REQ_TEXT, CH_LOWER_A);
        queue_request(REQ_TEXT, CHAR_UPPER_Z);
        queue_request(REQ_TEXT, 8'h00);
        queue_request(REQ_PATTERN, 8'h6B);
        queue_request(REQ_EOT, 8'h55);
        queue_request(REQ_TEXT, 8'hFF);
        queue_request(REQ_TEXT, 8'h40);
        queue_request(REQ_EOT, 8'h00);
        queue_request(REQ_EOT, 8'hAA);
        queue_request(REQ_CLEAR, 8'hFF);
        queue_request(REQ_EOT, 8'h01);
        queue_request(REQ_PATTERN, 8'h5B);
        queue_request(REQ_TEXT, 8'h7B);
        queue_request(REQ_TEXT, 8'h5B);
        queue_request(REQ_EOT, 8'h80);

        // random sequences; a few carry full pattern, full text, overflow
        seq_idx     = 0;
        small_items = 0;
        while (seq_idx <= 11 || small_items < 400 || eot_queued < 40) begin
            start_items = total_items;
            big = (seq_idx == 2 || seq_idx == 5 || seq_idx == 8 || seq_idx == 11);
            if ((big && seq_idx != 11) || (!big && $urandom_range(0, 5) != 0)) begin
                queue_request(REQ_CLEAR, 8'($urandom_range(0, 255)));
                gen_pat.delete();
            end
            if (seq_idx == 2) begin
                plen = PAT_CAP + 3;
            end else if (seq_idx == 5) begin
                plen = PAT_CAP;
            end else if (seq_idx == 8) begin
                plen = 1;
            end else if (seq_idx == 11) begin
                plen = 0;
            end else begin
                plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            end
            for (int k = 0; k < plen; k++) begin
                ch = (seq_idx == 8) ? 8'h71 : pick_char();
                queue_request(REQ_PATTERN, ch);
                if (gen_pat.size() < PAT_CAP) begin
                    gen_pat.push_back(ch);
                end
            end

            if (seq_idx == 2) begin
                tlen = 160;
            end else if (seq_idx == 5) begin
                tlen = 130;
            end else if (seq_idx == 8) begin
                tlen = TEXT_CAP;
            end else if (seq_idx == 11) begin
                tlen = TEXT_CAP + 3;
            end else begin
                tlen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
            end
            txt_buf.delete();
            for (int k = 0; k < tlen; k++) begin
                ch = pick_char();
                if (seq_idx == 8 && lower_byte(ch) == 8'h71) begin
                    ch = 8'h78;
                end
                txt_buf.push_back(ch);
            end
            // near miss: all of the pattern but its last byte
            if (!big && gen_pat.size() > 1 && gen_pat.size() - 1 <= tlen
                && $urandom_range(0, 2) == 0) begin
                off = $urandom_range(0, tlen - (gen_pat.size() - 1));
                for (int k = 0; k < gen_pat.size() - 1; k++) begin
                    txt_buf[off + k] = flip_case(gen_pat[k]);
                end
            end
            if (gen_pat.size() > 0 && gen_pat.size() <= tlen
                && (big || $urandom_range(0, 3) != 0)) begin
                if (seq_idx == 2) begin
                    off = 20;
                end else if (seq_idx == 5) begin
                    off = 2;
                end else if (seq_idx == 8) begin
                    off = tlen - 1;
                end else begin
                    off = $urandom_range(0, tlen - gen_pat.size());
                end
                for (int k = 0; k < gen_pat.size(); k++) begin
                    txt_buf[off + k] = flip_case(gen_pat[k]);
                end
            end
            for (int k = 0; k < tlen; k++) begin
                if (!big && $urandom_range(0, 19) == 0) begin
                    queue_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
                queue_request(REQ_TEXT, txt_buf[k]);
            end
            if (big || $urandom_range(0, 11) != 0) begin
                queue_request(REQ_EOT, 8'($urandom_range(0, 255)));
            end
            if (!big) begin
                small_items += total_items - start_items;
            end
            seq_idx++;
        end

        @(posedge i_clk);
        while (items_taken != total_items || due_reports.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
        if (due_reports.size() != 0) begin
            fault_count += due_reports.size();
            $display("%0d reports never arrived", due_reports.size());
        end
        if (fault_count == 0) begin
            $display("tb_case_insensitive_substring_search passed");
        end else begin
            $display("tb_case_insensitive_substring_search failed");
        end
        $finish;
    end

endmodule
